FILE: rtl/core/gstg_pkg.sv
// gstg_pkg: types, constants and angle helpers for the gimbal scan target generator
// used by every module under rtl/core; depends on nothing
package gstg_pkg;

    localparam int unsigned ANGLE_W = 32;
    localparam int unsigned IMU_W   = 31;
    localparam int unsigned STEP_W  = 29;
    localparam int unsigned LIMIT_W = 30;
    localparam int unsigned WIDE_W  = 36;
    localparam int unsigned CFG_IDX_W = 3;

    localparam int unsigned S_TDATA_W = 160;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 128;
    localparam int unsigned M_TUSER_W = 3;

    localparam logic signed [WIDE_W-1:0] Q_PI_W     = 36'sd843314857;
    localparam logic signed [WIDE_W-1:0] Q_TWO_PI_W = 36'sd1686629714;
    localparam logic signed [WIDE_W-1:0] S32_MAX_W  = 36'sd2147483647;
    localparam logic signed [WIDE_W-1:0] S32_MIN_W  = -36'sd2147483648;
    localparam longint Q_TWO_PI_L = 64'sd1686629714;

    localparam logic signed [ANGLE_W-1:0] RST_PITCH_UPPER = 32'sd140552478;
    localparam logic signed [ANGLE_W-1:0] RST_PITCH_LOWER = -32'sd140552478;
    localparam logic signed [ANGLE_W-1:0] RST_YAW_UPPER   = 32'sd843314856;
    localparam logic signed [ANGLE_W-1:0] RST_YAW_LOWER   = -32'sd843314857;
    localparam logic [STEP_W-1:0]         RST_PITCH_STEP  = 29'd53687;
    localparam logic [STEP_W-1:0]         RST_YAW_STEP    = 29'd134218;
    localparam logic [LIMIT_W-1:0]        RST_AIM_LIMIT   = 30'd140552478;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PITCH_UPPER     = 3'd0,
        CFG_PITCH_LOWER     = 3'd1,
        CFG_YAW_UPPER       = 3'd2,
        CFG_YAW_LOWER       = 3'd3,
        CFG_PITCH_STEP      = 3'd4,
        CFG_YAW_STEP        = 3'd5,
        CFG_AIM_PITCH_LIMIT = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_FAULT = 2'd0,
        MODE_AIM   = 2'd1,
        MODE_SCAN  = 2'd2
    } drive_mode_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch_upper;
        logic signed [ANGLE_W-1:0] pitch_lower;
        logic signed [ANGLE_W-1:0] yaw_upper;
        logic signed [ANGLE_W-1:0] yaw_lower;
        logic [STEP_W-1:0]         pitch_step;
        logic [STEP_W-1:0]         yaw_step;
        logic [LIMIT_W-1:0]        aim_pitch_limit;
    } cfg_t;

    typedef struct packed {
        logic                      motor_fault;
        logic                      aiming;
        logic signed [ANGLE_W-1:0] aim_pitch;
        logic signed [ANGLE_W-1:0] aim_yaw;
        logic signed [IMU_W-1:0]   imu_yaw;
        logic signed [ANGLE_W-1:0] measured_yaw;
        logic signed [ANGLE_W-1:0] measured_pitch;
    } req_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch_target;
        logic signed [ANGLE_W-1:0] yaw_target;
        logic signed [ANGLE_W-1:0] aim_yaw_max;
        logic signed [ANGLE_W-1:0] aim_yaw_min;
        drive_mode_t               drive_mode;
        logic                      clear_fault;
    } res_t;

    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [ANGLE_W-1:0] r;
        if (x > S32_MAX_W) begin
            r = ANGLE_W'(S32_MAX_W);
        end else if (x < S32_MIN_W) begin
            r = ANGLE_W'(S32_MIN_W);
        end else begin
            r = ANGLE_W'(x);
        end
        return r;
    endfunction

    // maps into [-pi, pi); input is within three turns of the range
    function automatic logic signed [ANGLE_W-1:0] wrap_q(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] base;
        logic signed [WIDE_W-1:0] cand;
        logic signed [WIDE_W-1:0] sel;
        base = x + Q_PI_W;
        sel  = base;
        for (int k = -3; k <= 3; k++) begin
            cand = base - WIDE_W'(longint'(k) * Q_TWO_PI_L);
            if (cand >= 0 && cand < Q_TWO_PI_W) begin
                sel = cand;
            end
        end
        return ANGLE_W'(sel - Q_PI_W);
    endfunction

endpackage

FILE: rtl/core/gstg_cfg.sv
// gstg_cfg: configuration register file for the scan target generator
// depends on gstg_pkg
module gstg_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gstg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gstg_pkg::ANGLE_W-1:0]    cfg_wdata,
    output gstg_pkg::cfg_t                  cfg
);
    import gstg_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pitch_upper     <= RST_PITCH_UPPER;
            cfg_reg.pitch_lower     <= RST_PITCH_LOWER;
            cfg_reg.yaw_upper       <= RST_YAW_UPPER;
            cfg_reg.yaw_lower       <= RST_YAW_LOWER;
            cfg_reg.pitch_step      <= RST_PITCH_STEP;
            cfg_reg.yaw_step        <= RST_YAW_STEP;
            cfg_reg.aim_pitch_limit <= RST_AIM_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PITCH_UPPER:     cfg_reg.pitch_upper     <= cfg_wdata;
                CFG_PITCH_LOWER:     cfg_reg.pitch_lower     <= cfg_wdata;
                CFG_YAW_UPPER:       cfg_reg.yaw_upper       <= cfg_wdata;
                CFG_YAW_LOWER:       cfg_reg.yaw_lower       <= cfg_wdata;
                CFG_PITCH_STEP:      cfg_reg.pitch_step      <= cfg_wdata[STEP_W-1:0];
                CFG_YAW_STEP:        cfg_reg.yaw_step        <= cfg_wdata[STEP_W-1:0];
                CFG_AIM_PITCH_LIMIT: cfg_reg.aim_pitch_limit <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/gstg_in_stage.sv
// gstg_in_stage: input register holding one request ahead of the core
// depends on gstg_pkg
module gstg_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  gstg_pkg::req_t s_req,
    output logic          req_vld,
    output gstg_pkg::req_t req,
    input  logic          req_take
);
    import gstg_pkg::*;

    logic vld_reg;
    logic vld_next;
    req_t req_reg;

    assign s_tready = !vld_reg || req_take;

    always_comb begin
        vld_next = vld_reg;
        if (s_tvalid && s_tready) begin
            vld_next = 1'b1;
        end else if (req_take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg <= s_req;
        end
    end

    assign req_vld = vld_reg;
    assign req     = req_reg;

endmodule

FILE: rtl/core/gstg_core.sv
// gstg_core: target state, per-tick aim/scan update and result register
// depends on gstg_pkg
module gstg_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  gstg_pkg::cfg_t cfg,
    input  logic           req_vld,
    input  gstg_pkg::req_t req,
    output logic           req_take,
    output logic           res_vld,
    output gstg_pkg::res_t res,
    input  logic           res_ready
);
    import gstg_pkg::*;

    logic signed [ANGLE_W-1:0] pitch_goal_reg, pitch_goal_next;
    logic signed [ANGLE_W-1:0] yaw_goal_reg, yaw_goal_next;
    logic signed [ANGLE_W-1:0] bound_max_reg, bound_max_next;
    logic signed [ANGLE_W-1:0] bound_min_reg, bound_min_next;
    logic pitch_rising_reg, pitch_rising_next;
    logic yaw_rising_reg, yaw_rising_next;
    logic was_scanning_reg, was_scanning_next;
    logic res_vld_reg;
    res_t res_reg;

    drive_mode_t mode;
    logic signed [ANGLE_W-1:0] mx, mn, p, y, pg, yg;
    logic signed [ANGLE_W:0]   ap, lim;

    assign req_take = req_vld && (!res_vld_reg || res_ready);

    always_comb begin
        pitch_goal_next   = pitch_goal_reg;
        yaw_goal_next     = yaw_goal_reg;
        bound_max_next    = bound_max_reg;
        bound_min_next    = bound_min_reg;
        pitch_rising_next = pitch_rising_reg;
        yaw_rising_next   = yaw_rising_reg;
        was_scanning_next = was_scanning_reg;
        mode = MODE_FAULT;
        mx = '0;
        mn = '0;
        p  = '0;
        y  = '0;
        pg = '0;
        yg = '0;
        ap  = (ANGLE_W+1)'(req.aim_pitch);
        lim = $signed({3'b000, cfg.aim_pitch_limit});
        if (req.motor_fault) begin
            mode = MODE_FAULT;
        end else if (req.aiming) begin
            mode = MODE_AIM;
            mx = wrap_q(WIDE_W'(req.imu_yaw) + WIDE_W'(cfg.yaw_upper)
                        - WIDE_W'(req.measured_yaw));
            mn = wrap_q(WIDE_W'(req.imu_yaw) + WIDE_W'(cfg.yaw_lower)
                        - WIDE_W'(req.measured_yaw));
            if (mx < mn) begin
                bound_max_next = sat32(WIDE_W'(mx) + Q_TWO_PI_W);
            end else begin
                bound_max_next = mx;
            end
            bound_min_next = mn;
            if (ap > lim) begin
                ap = lim;
            end
            if (ap < -lim) begin
                ap = -lim;
            end
            pitch_goal_next   = ANGLE_W'(ap);
            yaw_goal_next     = req.aim_yaw;
            was_scanning_next = 1'b0;
        end else begin
            mode = MODE_SCAN;
            pg = was_scanning_reg ? pitch_goal_reg : req.measured_pitch;
            yg = was_scanning_reg ? yaw_goal_reg : req.measured_yaw;
            if (pitch_rising_reg) begin
                p = sat32(WIDE_W'(pg) + $signed({7'b0, cfg.pitch_step}));
                if (p >= cfg.pitch_upper) begin
                    pitch_rising_next = 1'b0;
                end
            end else begin
                p = sat32(WIDE_W'(pg) - $signed({7'b0, cfg.pitch_step}));
                if (p <= cfg.pitch_lower) begin
                    pitch_rising_next = 1'b1;
                end
            end
            y = wrap_q(WIDE_W'(yg));
            if (yaw_rising_reg) begin
                if (y < cfg.yaw_upper) begin
                    y = sat32(WIDE_W'(y) + $signed({7'b0, cfg.yaw_step}));
                end else begin
                    yaw_rising_next = 1'b0;
                    y = cfg.yaw_upper;
                end
            end else begin
                if (y > cfg.yaw_lower) begin
                    y = sat32(WIDE_W'(y) - $signed({7'b0, cfg.yaw_step}));
                end else begin
                    yaw_rising_next = 1'b1;
                    y = cfg.yaw_lower;
                end
            end
            pitch_goal_next   = p;
            yaw_goal_next     = y;
            was_scanning_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_goal_reg   <= '0;
            yaw_goal_reg     <= '0;
            bound_max_reg    <= '0;
            bound_min_reg    <= '0;
            pitch_rising_reg <= 1'b1;
            yaw_rising_reg   <= 1'b1;
            was_scanning_reg <= 1'b1;
            res_vld_reg      <= 1'b0;
        end else begin
            if (req_take) begin
                pitch_goal_reg   <= pitch_goal_next;
                yaw_goal_reg     <= yaw_goal_next;
                bound_max_reg    <= bound_max_next;
                bound_min_reg    <= bound_min_next;
                pitch_rising_reg <= pitch_rising_next;
                yaw_rising_reg   <= yaw_rising_next;
                was_scanning_reg <= was_scanning_next;
                res_vld_reg      <= 1'b1;
            end else if (res_ready) begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_take) begin
            res_reg.pitch_target <= pitch_goal_next;
            res_reg.yaw_target   <= yaw_goal_next;
            res_reg.aim_yaw_max  <= bound_max_next;
            res_reg.aim_yaw_min  <= bound_min_next;
            res_reg.drive_mode   <= mode;
            res_reg.clear_fault  <= req.motor_fault;
        end
    end

    assign res_vld = res_vld_reg;
    assign res     = res_reg;

    // fault request leaves all state untouched
    a_fault_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        req_take && req.motor_fault |=> pitch_goal_reg == $past(pitch_goal_reg)
            && yaw_goal_reg == $past(yaw_goal_reg)
            && was_scanning_reg == $past(was_scanning_reg))
        else $error("state changed on fault request");

    a_bound_order: assert property (@(posedge aclk) disable iff (!aresetn)
        req_take && !req.motor_fault && req.aiming |=> bound_max_reg >= bound_min_reg)
        else $error("aim yaw bounds out of order");

    a_aim_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        req_take && !req.motor_fault && req.aiming
            |=> (ANGLE_W+1)'(pitch_goal_reg) <= $past(lim)
                && (ANGLE_W+1)'(pitch_goal_reg) >= -$past(lim))
        else $error("aim pitch outside clamp");

    a_scan_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        req_take |=> was_scanning_reg == (res_reg.drive_mode == MODE_SCAN)
            || res_reg.drive_mode == MODE_FAULT)
        else $error("scan flag disagrees with mode");

endmodule

FILE: rtl/core/gimbal_scan_target_generator.sv
// gimbal_scan_target_generator: top level, stream ports and config port
// depends on gstg_pkg, gstg_cfg, gstg_in_stage, gstg_core
// a request goes through the input register, then the result register, where m_tready can stall it
// throughput: one request per cycle unless m_tready stalls the result register
// s_tready falls only while the input register is full and the result is stalled
// reset: synchronous active-low aresetn clears both stages, restores config defaults
//   and the scan state (goals zero, both sweeps rising, scan mode assumed)
module gimbal_scan_target_generator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // aim_pitch, aim_yaw, imu_yaw, measured_yaw, measured_pitch, zero pad
    input  logic [gstg_pkg::S_TDATA_W-1:0]   s_tdata,
    // motor_fault, aiming
    input  logic [gstg_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pitch_target, yaw_target, aim_yaw_max, aim_yaw_min
    output logic [gstg_pkg::M_TDATA_W-1:0]   m_tdata,
    // drive_mode, clear_fault
    output logic [gstg_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [gstg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gstg_pkg::ANGLE_W-1:0]     cfg_wdata
);
    import gstg_pkg::*;

    cfg_t cfg;
    req_t s_req, req;
    res_t res;
    logic req_vld, req_take;

    assign s_req.motor_fault    = s_tuser[0];
    assign s_req.aiming         = s_tuser[1];
    assign s_req.aim_pitch      = s_tdata[31:0];
    assign s_req.aim_yaw        = s_tdata[63:32];
    assign s_req.imu_yaw        = s_tdata[94:64];
    assign s_req.measured_yaw   = s_tdata[126:95];
    assign s_req.measured_pitch = s_tdata[158:127];

    gstg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gstg_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_req    (s_req),
        .req_vld  (req_vld),
        .req      (req),
        .req_take (req_take)
    );

    gstg_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .req_vld   (req_vld),
        .req       (req),
        .req_take  (req_take),
        .res_vld   (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {res.aim_yaw_min, res.aim_yaw_max, res.yaw_target, res.pitch_target};
    assign m_tuser = {res.clear_fault, res.drive_mode};

endmodule

FILE: tb/gimbal_scan_target_generator_tb.sv
// gimbal_scan_target_generator_tb: self-checking bench for the gimbal scan target generator
// drives requests and register writes, predicts each target update and checks the m_ stream
// depends on gstg_pkg and gimbal_scan_target_generator
module gimbal_scan_target_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gstg_pkg::*;

    localparam int     CLK_HALF     = 6;
    localparam int     RESET_CYCLES = 10;
    localparam int     IDLE_PCT     = 29;
    localparam int     PHASES       = 9;
    localparam int     PHASE_ITEMS  = 155;
    localparam int     CALM_PHASE   = 5;
    localparam int     STALL_LIMIT  = 4000;
    localparam int     SHOW_LIMIT   = 10;
    localparam int     PLAN_ROWS    = 22;
    localparam longint ANG_PI       = 64'sd843314857;
    localparam longint ANG_TWO_PI   = 64'sd1686629714;
    localparam longint S32_HI       = 64'sd2147483647;
    localparam longint S32_LO       = -64'sd2147483648;
    localparam int     STEP_MAX     = 268435456;
    localparam int     LIMIT_MAX    = 843314857;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ANGLE_W-1:0]   cfg_wdata = '0;

    longint tgt_pitch, tgt_yaw, bnd_max, bnd_min;
    bit     pitch_up, yaw_up, scanning_prev;
    longint set_pitch_hi, set_pitch_lo, set_yaw_hi, set_yaw_lo;
    longint set_pitch_step, set_yaw_step, set_aim_lim;

    res_t        pending_targets[$];
    int          sent_reqs;
    int          seen_results;
    int          mismatches;
    int          settings_used;
    int          quiet;
    bit          steady;
    int          run_left;
    drive_mode_t run_kind;

    typedef struct {
        bit          fault;
        bit          aim;
        int          ap;
        int          ay;
        int          iy;
        int          my;
        int          mp;
        bit          typed;
        int          w_pitch;
        int          w_yaw;
        int          w_max;
        int          w_min;
        drive_mode_t w_mode;
        bit          w_clr;
    } plan_row_t;

    plan_row_t plan [PLAN_ROWS] = '{
        '{1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, MODE_FAULT, 1},
        '{0, 1, 32'h7fffffff, 32'h80000000, 0, 0, 0,
          1, 140552478, 32'h80000000, 843314856, -843314857, MODE_AIM, 0},
        '{0, 1, 32'h80000000, 32'h7fffffff, 0, 0, 0,
          1, -140552478, 32'h7fffffff, 843314856, -843314857, MODE_AIM, 0},
        '{1, 1, 12345, -777, 5000, 99, -99,
          1, -140552478, 32'h7fffffff, 843314856, -843314857, MODE_FAULT, 1},
        '{0, 0, 0, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 0, -1, -1, 0, 32'h12345678, 32'h1234, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 1, 0, 0, 843314857, 32'h80000000, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 1, 140552478, 1, -843314857, 32'h7fffffff, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 1, -140552478, -1, 0, -1343314857, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 1, 140552479, 0, 1, 0, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 1, -140552479, 0, -1, 0, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 0, 0, 0, 0, 843314846, 140552000, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{1, 0, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_FAULT, 0}
    };

    gimbal_scan_target_generator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    function automatic longint fold_angle(input longint x);
        longint r;
        r = (x + ANG_PI) % ANG_TWO_PI;
        if (r < 0) begin
            r += ANG_TWO_PI;
        end
        return r - ANG_PI;
    endfunction

    function automatic longint clip_s32(input longint x);
        if (x > S32_HI) begin
            return S32_HI;
        end
        if (x < S32_LO) begin
            return S32_LO;
        end
        return x;
    endfunction

    task automatic reset_model();
        set_pitch_hi   = 140552478;
        set_pitch_lo   = -140552478;
        set_yaw_hi     = 843314856;
        set_yaw_lo     = -843314857;
        set_pitch_step = 53687;
        set_yaw_step   = 134218;
        set_aim_lim    = 140552478;
        tgt_pitch      = 0;
        tgt_yaw        = 0;
        bnd_max        = 0;
        bnd_min        = 0;
        pitch_up       = 1'b1;
        yaw_up         = 1'b1;
        scanning_prev  = 1'b1;
    endtask

    function automatic res_t next_targets(input req_t rq);
        longint iy, my, ap, mx, mn, p, y;
        res_t   o;
        iy = longint'($signed(rq.imu_yaw));
        my = longint'($signed(rq.measured_yaw));
        o.clear_fault = 1'b0;
        if (rq.motor_fault) begin
            o.drive_mode  = MODE_FAULT;
            o.clear_fault = 1'b1;
        end else if (rq.aiming) begin
            mx = fold_angle(iy + (set_yaw_hi - my));
            mn = fold_angle(iy + (set_yaw_lo - my));
            if (mx < mn) begin
                mx += ANG_TWO_PI;
            end
            bnd_max = clip_s32(mx);
            bnd_min = mn;
            ap = longint'($signed(rq.aim_pitch));
            if (ap > set_aim_lim) begin
                ap = set_aim_lim;
            end
            if (ap < -set_aim_lim) begin
                ap = -set_aim_lim;
            end
            tgt_pitch     = ap;
            tgt_yaw       = longint'($signed(rq.aim_yaw));
            scanning_prev = 1'b0;
            o.drive_mode  = MODE_AIM;
        end else begin
            if (!scanning_prev) begin
                tgt_pitch = longint'($signed(rq.measured_pitch));
                tgt_yaw   = my;
            end
            p = tgt_pitch;
            if (pitch_up) begin
                p = clip_s32(p + set_pitch_step);
                if (p >= set_pitch_hi) begin
                    pitch_up = 1'b0;
                end
            end else begin
                p = clip_s32(p - set_pitch_step);
                if (p <= set_pitch_lo) begin
                    pitch_up = 1'b1;
                end
            end
            tgt_pitch = p;
            y = fold_angle(tgt_yaw);
            if (yaw_up) begin
                if (y < set_yaw_hi) begin
                    y = clip_s32(y + set_yaw_step);
                end else begin
                    yaw_up = 1'b0;
                    y      = set_yaw_hi;
                end
            end else begin
                if (y > set_yaw_lo) begin
                    y = clip_s32(y - set_yaw_step);
                end else begin
                    yaw_up = 1'b1;
                    y      = set_yaw_lo;
                end
            end
            tgt_yaw       = y;
            scanning_prev = 1'b1;
            o.drive_mode  = MODE_SCAN;
        end
        o.pitch_target = 32'(tgt_pitch);
        o.yaw_target   = 32'(tgt_yaw);
        o.aim_yaw_max  = 32'(bnd_max);
        o.aim_yaw_min  = 32'(bnd_min);
        return o;
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle();
        logic [ANGLE_W-1:0] v;
        case ($urandom_range(6))
            0, 1: v = $urandom;
            2, 3: v = 32'(longint'($urandom_range(32'd1686629714)) - ANG_PI);
            4: begin
                case ($urandom_range(5))
                    0: v = 32'h7fffffff;
                    1: v = 32'h80000000;
                    2: v = '0;
                    3: v = '1;
                    4: v = 32'(ANG_PI);
                    default: v = 32'(-ANG_PI);
                endcase
            end
            5: begin
                v = 32'(set_aim_lim - 1 + $urandom_range(2));
                if ($urandom_range(1)) begin
                    v = -v;
                end
            end
            default: v = 32'(longint'($urandom_range(32'd2097152)) - 1048576);
        endcase
        return v;
    endfunction

    function automatic logic [IMU_W-1:0] pick_imu();
        logic [IMU_W-1:0] v;
        if ($urandom_range(9) == 0) begin
            v = $urandom_range(1) ? 31'(ANG_PI) : 31'(-ANG_PI);
        end else begin
            v = 31'(longint'($urandom_range(32'd1686629714)) - ANG_PI);
        end
        return v;
    endfunction

    task automatic draw_req(output req_t rq);
        int          w;
        drive_mode_t kind;
        if (run_left == 0) begin
            w = $urandom_range(99);
            if (w < 10) begin
                run_kind = MODE_FAULT;
                run_left = $urandom_range(3, 1);
            end else if (w < 45) begin
                run_kind = MODE_AIM;
                run_left = $urandom_range(10, 1);
            end else begin
                run_kind = MODE_SCAN;
                run_left = $urandom_range(120, 10);
            end
        end
        run_left--;
        kind = run_kind;
        if ($urandom_range(99) < 8) begin
            kind = drive_mode_t'($urandom_range(2));
        end
        rq.motor_fault    = (kind == MODE_FAULT);
        rq.aiming         = (kind == MODE_AIM) || (kind == MODE_FAULT && $urandom_range(1));
        rq.aim_pitch      = pick_angle();
        rq.aim_yaw        = pick_angle();
        rq.imu_yaw        = pick_imu();
        rq.measured_yaw   = pick_angle();
        rq.measured_pitch = pick_angle();
    endtask

    task automatic send_req(input req_t rq, input bit typed, input res_t want);
        res_t guess;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, rq.measured_pitch, rq.measured_yaw, rq.imu_yaw,
                     rq.aim_yaw, rq.aim_pitch};
        s_tuser  <= {rq.aiming, rq.motor_fault};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        guess = next_targets(rq);
        pending_targets.push_back(typed ? want : guess);
        sent_reqs++;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
    endtask

    task automatic apply_settings(input longint pu, input longint pl, input longint yu,
                                  input longint yl, input longint ps, input longint ys,
                                  input longint al);
        set_pitch_hi   = pu;
        set_pitch_lo   = pl;
        set_yaw_hi     = yu;
        set_yaw_lo     = yl;
        set_pitch_step = ps;
        set_yaw_step   = ys;
        set_aim_lim    = al;
        put_reg(CFG_PITCH_UPPER, 32'(pu));
        put_reg(CFG_PITCH_LOWER, 32'(pl));
        put_reg(CFG_YAW_UPPER, 32'(yu));
        put_reg(CFG_YAW_LOWER, 32'(yl));
        put_reg(CFG_PITCH_STEP, 32'(ps));
        put_reg(CFG_YAW_STEP, 32'(ys));
        put_reg(CFG_AIM_PITCH_LIMIT, 32'(al));
        put_reg(CFG_SPARE, $urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic pick_settings(input int ph);
        case (ph)
            1: apply_settings(S32_HI, S32_LO, S32_HI, S32_LO, STEP_MAX, STEP_MAX, LIMIT_MAX);
            2: apply_settings(0, 0, 0, 0, 0, 0, 0);
            3: apply_settings(-100000000, 100000000, -500000000, 500000000,
                              20000000, 30000000, 300000000);
            default: begin
                apply_settings($urandom_range(LIMIT_MAX), -longint'($urandom_range(LIMIT_MAX)),
                               $urandom_range(LIMIT_MAX), -longint'($urandom_range(LIMIT_MAX)),
                               $urandom_range(STEP_MAX) >> $urandom_range(8),
                               $urandom_range(STEP_MAX) >> $urandom_range(8),
                               $urandom_range(LIMIT_MAX));
            end
        endcase
    endtask

    task automatic settle();
        while (pending_targets.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2) @(posedge aclk);
    endtask

    task automatic check_targets(input logic [M_TDATA_W-1:0] d, input logic [M_TUSER_W-1:0] u);
        res_t got;
        res_t want;
        got.pitch_target = d[31:0];
        got.yaw_target   = d[63:32];
        got.aim_yaw_max  = d[95:64];
        got.aim_yaw_min  = d[127:96];
        got.drive_mode   = drive_mode_t'(u[1:0]);
        got.clear_fault  = u[2];
        seen_results++;
        if (pending_targets.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT) begin
                $display("result %0d arrived with no request pending", seen_results);
            end
        end else begin
            want = pending_targets.pop_front();
            if (got.pitch_target !== want.pitch_target || got.yaw_target !== want.yaw_target ||
                got.aim_yaw_max !== want.aim_yaw_max || got.aim_yaw_min !== want.aim_yaw_min ||
                got.drive_mode !== want.drive_mode || got.clear_fault !== want.clear_fault) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT) begin
                    $display("result %0d expected pitch %0d yaw %0d max %0d min %0d mode %0d clr %0b",
                             seen_results, want.pitch_target, want.yaw_target, want.aim_yaw_max,
                             want.aim_yaw_min, want.drive_mode, want.clear_fault);
                    $display("result %0d actual   pitch %0d yaw %0d max %0d min %0d mode %0d clr %0b",
                             seen_results, got.pitch_target, got.yaw_target, got.aim_yaw_max,
                             got.aim_yaw_min, got.drive_mode, got.clear_fault);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        if (aresetn && m_tvalid && m_tready) begin
            check_targets(m_tdata, m_tuser);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        req_t rq;
        res_t want;
        reset_model();
        want = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < PLAN_ROWS; i++) begin
            rq.motor_fault    = plan[i].fault;
            rq.aiming         = plan[i].aim;
            rq.aim_pitch      = plan[i].ap;
            rq.aim_yaw        = plan[i].ay;
            rq.imu_yaw        = 31'(plan[i].iy);
            rq.measured_yaw   = plan[i].my;
            rq.measured_pitch = plan[i].mp;
            want.pitch_target = plan[i].w_pitch;
            want.yaw_target   = plan[i].w_yaw;
            want.aim_yaw_max  = plan[i].w_max;
            want.aim_yaw_min  = plan[i].w_min;
            want.drive_mode   = plan[i].w_mode;
            want.clear_fault  = plan[i].w_clr;
            send_req(rq, plan[i].typed, want);
        end
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                s_tvalid <= 1'b0;
                settle();
                pick_settings(ph);
            end
            steady = (ph == CALM_PHASE);
            repeat (PHASE_ITEMS) begin
                draw_req(rq);
                send_req(rq, 1'b0, want);
            end
        end
        s_tvalid <= 1'b0;
        settle();
        $display("covered %0d requests in fault, aim and scan runs, %0d results checked",
                 sent_reqs, seen_results);
        $display("register settings applied after reset: %0d, mismatches: %0d",
                 settings_used, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
